// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the decoder RTL; they compile to nothing under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks a property on every rising clock edge outside reset.
`define MCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checks that a condition never holds outside reset.
`define MCD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define MCD_ASSERT(lbl, prop, msg)
`define MCD_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== hdl/mcd_pkg.sv =====
// Types, constants and the letter lookup shared by the decoder modules.
package mcd_pkg;

  localparam int TimeBitsDefault = 32;
  localparam int SampleW         = 12;
  localparam int CfgDataW        = 16;
  localparam int CfgIdxW         = 3;
  localparam int CharW           = 7;
  localparam int LenW            = 3;
  localparam int SymW            = 4;
  localparam int NumLetters      = 26;

  localparam logic [LenW-1:0]  MaxSymbols   = 3'd4;
  localparam logic [LenW-1:0]  TooLong      = 3'd5;
  localparam logic [CfgDataW-1:0] WordGapLimit = 16'd65;
  localparam logic [CharW-1:0] SpaceChar    = 7'd32;
  localparam logic [CharW-1:0] LetterBase   = 7'd65;
  localparam logic [CharW-1:0] NoChar       = 7'd0;

  typedef enum logic {
    CmdTick   = 1'b0,
    CmdSample = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegLevelThreshold = 3'd0,
    RegDotMin         = 3'd1,
    RegDotMax         = 3'd2,
    RegDashMin        = 3'd3,
    RegDashMax        = 3'd4,
    RegLetterGapMin   = 3'd5,
    RegLetterGapMax   = 3'd6,
    RegWordGapMin     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [SampleW-1:0]  level_threshold;
    logic [CfgDataW-1:0] dot_min;
    logic [CfgDataW-1:0] dot_max;
    logic [CfgDataW-1:0] dash_min;
    logic [CfgDataW-1:0] dash_max;
    logic [CfgDataW-1:0] letter_gap_min;
    logic [CfgDataW-1:0] letter_gap_max;
    logic [CfgDataW-1:0] word_gap_min;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    level_threshold: 12'd2111,
    dot_min:         16'd7,
    dot_max:         16'd13,
    dash_min:        16'd17,
    dash_max:        16'd23,
    letter_gap_min:  16'd33,
    letter_gap_max:  16'd39,
    word_gap_min:    16'd55
  };

  // One decoded character headed for the output register.
  typedef struct packed {
    logic             valid;
    logic [CharW-1:0] character;
  } res_t;

  // Symbol i of a code sits in bit i, with 1 for a dash.
  typedef struct packed {
    logic [LenW-1:0] len;
    logic [SymW-1:0] bits;
  } letter_t;

  localparam letter_t LetterTable [NumLetters] = '{
    '{3'd2, 4'd2},  '{3'd4, 4'd1},  '{3'd4, 4'd5},  '{3'd3, 4'd1},
    '{3'd1, 4'd0},  '{3'd4, 4'd4},  '{3'd3, 4'd3},  '{3'd4, 4'd0},
    '{3'd2, 4'd0},  '{3'd4, 4'd14}, '{3'd3, 4'd5},  '{3'd4, 4'd2},
    '{3'd2, 4'd3},  '{3'd2, 4'd1},  '{3'd3, 4'd7},  '{3'd4, 4'd6},
    '{3'd4, 4'd11}, '{3'd3, 4'd2},  '{3'd3, 4'd0},  '{3'd1, 4'd1},
    '{3'd3, 4'd4},  '{3'd4, 4'd8},  '{3'd3, 4'd6},  '{3'd4, 4'd9},
    '{3'd4, 4'd13}, '{3'd4, 4'd3}
  };

  // Returns the ASCII letter for a code, or NoChar when none matches.
  // Empty and too long codes never match since no table entry has that length.
  function automatic logic [CharW-1:0] lookup_letter(input logic [LenW-1:0] len,
                                                      input logic [SymW-1:0] bits);
    logic [CharW-1:0] ch;
    ch = NoChar;
    for (int i = 0; i < NumLetters; i++) begin
      if (LetterTable[i].len == len && LetterTable[i].bits == bits) begin
        ch = LetterBase + CharW'(i);
      end
    end
    return ch;
  endfunction

endpackage

// ===== hdl/mcd_in_if.sv =====
// Input channel: a timer tick or a converter sample per transaction.
interface mcd_in_if import mcd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [SampleW-1:0] sample;

  modport source (output valid, output cmd, output sample, input ready);
  modport sink (input valid, input cmd, input sample, output ready);
endinterface

// ===== hdl/mcd_out_if.sv =====
// Output channel: one decoded ASCII character per transaction.
interface mcd_out_if import mcd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] character;

  modport source (output valid, output character, input ready);
  modport sink (input valid, input character, output ready);
endinterface

// ===== hdl/mcd_cfg_regs.sv =====
// Configuration register file for the decoder thresholds and timing windows.
module mcd_cfg_regs import mcd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        RegLevelThreshold: cfg_d.level_threshold = cfg_data_i[SampleW-1:0];
        RegDotMin:         cfg_d.dot_min         = cfg_data_i;
        RegDotMax:         cfg_d.dot_max         = cfg_data_i;
        RegDashMin:        cfg_d.dash_min        = cfg_data_i;
        RegDashMax:        cfg_d.dash_max        = cfg_data_i;
        RegLetterGapMin:   cfg_d.letter_gap_min  = cfg_data_i;
        RegLetterGapMax:   cfg_d.letter_gap_max  = cfg_data_i;
        RegWordGapMin:     cfg_d.word_gap_min    = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/mcd_core.sv =====
// Input register, decoder state and the combinational symbol and letter decode.
`include "assert_macros.svh"

module mcd_core import mcd_pkg::*; #(
  parameter int TimeBits = TimeBitsDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  mcd_in_if.sink in_i,
  input  logic   out_ready_i,
  output res_t   res_o
);

  localparam int CmpW = (TimeBits > CfgDataW) ? TimeBits : CfgDataW;

  // Input register.
  logic               in_valid_q;
  cmd_e               cmd_q;
  logic [SampleW-1:0] sample_q;
  logic               fire;

  // Decoder state. The elapsed count is the time since the last pulse start,
  // which serves both as pulse length and as gap time.
  logic [TimeBits-1:0] elapsed_q, elapsed_d;
  logic                sig_on_q, sig_on_d;
  logic [SymW-1:0]     code_sym_q, code_sym_d;
  logic [LenW-1:0]     code_len_q, code_len_d;
  logic                armed_q, armed_d;
  logic                seen_q, seen_d;

  logic [CmpW-1:0]  elapsed_x;
  logic             is_on;
  logic             dot_hit, dash_hit, letter_win, word_win;
  logic [SymW-1:0]  sym_cur;
  logic [LenW-1:0]  len_cur;
  logic [CharW-1:0] letter_ch;
  logic             letter_emit;

  assign fire       = in_valid_q && out_ready_i;
  assign in_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q    <= cmd_e'(in_i.cmd);
      sample_q <= in_i.sample;
    end
  end

  assign elapsed_x  = CmpW'(elapsed_q);
  assign is_on      = sample_q > cfg_i.level_threshold;
  assign dot_hit    = elapsed_x > CmpW'(cfg_i.dot_min) && elapsed_x < CmpW'(cfg_i.dot_max);
  assign dash_hit   = elapsed_x > CmpW'(cfg_i.dash_min) && elapsed_x < CmpW'(cfg_i.dash_max);
  assign letter_win = elapsed_x > CmpW'(cfg_i.letter_gap_min) &&
                      elapsed_x < CmpW'(cfg_i.letter_gap_max);
  assign word_win   = elapsed_x > CmpW'(cfg_i.word_gap_min) &&
                      elapsed_x < CmpW'(WordGapLimit);

  // Code after the falling edge of a pulse, if this sample ends one.
  always_comb begin
    sym_cur = code_sym_q;
    len_cur = code_len_q;
    if (sig_on_q && (dot_hit || dash_hit)) begin
      if (code_len_q >= MaxSymbols) begin
        len_cur = TooLong;
      end else begin
        sym_cur = code_sym_q | (SymW'(!dot_hit) << code_len_q[1:0]);
        len_cur = code_len_q + 3'd1;
      end
    end
  end

  assign letter_ch = lookup_letter(len_cur, sym_cur);

  always_comb begin
    elapsed_d       = elapsed_q;
    sig_on_d        = sig_on_q;
    code_sym_d      = code_sym_q;
    code_len_d      = code_len_q;
    armed_d         = armed_q;
    seen_d          = seen_q;
    letter_emit     = 1'b0;
    res_o.valid     = 1'b0;
    res_o.character = NoChar;
    if (fire) begin
      unique case (cmd_q)
        CmdTick: begin
          elapsed_d = elapsed_q + TimeBits'(1);
        end
        CmdSample: begin
          if (is_on) begin
            if (!sig_on_q) begin
              sig_on_d  = 1'b1;
              elapsed_d = '0;
            end
          end else begin
            sig_on_d   = 1'b0;
            code_sym_d = sym_cur;
            code_len_d = len_cur;
            if (letter_win && len_cur != '0) begin
              if (letter_ch != NoChar) begin
                letter_emit     = 1'b1;
                res_o.valid     = 1'b1;
                res_o.character = letter_ch;
                seen_d          = 1'b1;
              end
              armed_d    = 1'b1;
              code_sym_d = '0;
              code_len_d = '0;
            end
            // A letter in this transaction takes precedence; the space stays armed.
            if (!letter_emit && word_win && seen_q && armed_d) begin
              res_o.valid     = 1'b1;
              res_o.character = SpaceChar;
              armed_d         = 1'b0;
            end
          end
        end
        default: begin
          elapsed_d = elapsed_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q  <= '0;
      sig_on_q   <= 1'b0;
      code_sym_q <= '0;
      code_len_q <= '0;
      armed_q    <= 1'b0;
      seen_q     <= 1'b0;
    end else begin
      elapsed_q  <= elapsed_d;
      sig_on_q   <= sig_on_d;
      code_sym_q <= code_sym_d;
      code_len_q <= code_len_d;
      armed_q    <= armed_d;
      seen_q     <= seen_d;
    end
  end

  `MCD_ASSERT_NEVER(a_len_range, code_len_q > TooLong, "code length out of range")
  `MCD_ASSERT(a_too_long_frozen, (code_len_q == TooLong) |=> ((code_len_q == TooLong && $stable(code_sym_q)) || code_len_q == '0), "too long code changed")
  `MCD_ASSERT(a_rise_clears, (fire && cmd_q == CmdSample && is_on && !sig_on_q) |=> (sig_on_q && elapsed_q == '0), "pulse start not recorded")
  `MCD_ASSERT(a_space_after_letter, (res_o.valid && res_o.character == SpaceChar) |-> seen_q, "space without a prior letter")
  `MCD_ASSERT(a_idle_holds, !fire |=> ($stable(code_len_q) && $stable(elapsed_q)), "state moved without a transaction")

endmodule

// ===== hdl/mcd_out_reg.sv =====
// Output register that holds a decoded character until the sink takes it.
`include "assert_macros.svh"

module mcd_out_reg import mcd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_t      res_i,
  output logic      can_accept_o,
  mcd_out_if.source out_o
);

  logic             valid_q, valid_d;
  logic [CharW-1:0] char_q;

  assign can_accept_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (can_accept_o) begin
      valid_d = res_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_accept_o && res_i.valid) begin
      char_q <= res_i.character;
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.character = char_q;

  `MCD_ASSERT_NEVER(a_no_overwrite, res_i.valid && !can_accept_o, "result dropped while output stalled")
  `MCD_ASSERT(a_char_legal, valid_q |-> (char_q == SpaceChar || (char_q >= LetterBase && char_q <= LetterBase + 7'd25)), "illegal character held")
  `MCD_ASSERT(a_hold_stalled, (valid_q && !out_o.ready) |=> (valid_q && $stable(char_q)), "stalled character changed")

endmodule

// ===== hdl/morse_code_decoder_top.sv =====
// Top level of the Morse code decoder: config registers, decode core and output register.
//
// The decoder takes one transaction per clock cycle on its input channel, either a timer
// tick or a 12-bit converter sample, and returns zero or one ASCII character per input
// (A to Z, or a space between words). Each input is first captured in an input register;
// once the output register can accept, the decode core updates its state from it and
// loads any character into that register, which holds it valid on the output until the
// sink takes it. The sustained rate is one input per cycle while the output is not
// stalled; the input stalls only while the output register holds a character the sink
// has not taken. Configuration writes should be made while no input is in flight.
module morse_code_decoder_top import mcd_pkg::*; #(
  parameter int TimeBits = TimeBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  mcd_in_if.sink              in_i,
  mcd_out_if.source           out_o
);

  cfg_t cfg;
  res_t res;
  logic out_can_accept;

  mcd_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  mcd_core #(
    .TimeBits (TimeBits)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_i        (in_i),
    .out_ready_i (out_can_accept),
    .res_o       (res)
  );

  mcd_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_i        (res),
    .can_accept_o (out_can_accept),
    .out_o        (out_o)
  );

endmodule
